// File: hdl/vrt_pkg.sv
package vrt_pkg;

    // default widths for the top-level parameters
    localparam int CELL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    // fixed field and datapath widths
    localparam int POS_W    = 32;
    localparam int DIR_W    = 16;
    localparam int OUT_W    = 16;
    localparam int REACH_W  = 10;
    localparam int T_W      = 32;
    localparam int N_AXES   = 3;
    localparam int AXIS_W   = 2;
    localparam int REACH_SHIFT = 16;

    localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(100);
    localparam logic [AXIS_W-1:0]  AXIS_FIRST  = AXIS_W'(0);
    localparam logic [AXIS_W-1:0]  AXIS_LAST   = AXIS_W'(N_AXES - 1);

    // transaction kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // step direction codes, two-bit signed
    localparam logic signed [1:0] SIGN_NONE = 2'sb00;
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } cmd_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] cell_x;
        logic signed [OUT_W-1:0] cell_y;
        logic signed [OUT_W-1:0] cell_z;
        logic signed [OUT_W-1:0] prior_x;
        logic signed [OUT_W-1:0] prior_y;
        logic signed [OUT_W-1:0] prior_z;
        logic                    at_end;
    } res_t;

    // shared divider request and response
    typedef struct packed {
        logic             start;
        logic [T_W-1:0]   num;
        logic [DIR_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [T_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_END,
        ST_DIV_T,
        ST_DIV_S,
        ST_CHECK,
        ST_EMIT
    } seq_state_t;

    // axis with the smallest crossing, a tie goes to the later axis (z over y over x)
    function automatic logic [AXIS_W-1:0] pick_axis(
        input logic [T_W-1:0] t0,
        input logic [T_W-1:0] t1,
        input logic [T_W-1:0] t2
    );
        logic [AXIS_W-1:0] a;
        if (t0 < t1 && t0 < t2)
            a = AXIS_W'(0);
        else if (t1 < t2)
            a = AXIS_W'(1);
        else
            a = AXIS_W'(2);
        return a;
    endfunction

    // saturating add of two crossing times
    function automatic logic [T_W-1:0] sat_add(
        input logic [T_W-1:0] a,
        input logic [T_W-1:0] b
    );
        logic [T_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[T_W] ? {T_W{1'b1}} : s[T_W-1:0];
    endfunction

endpackage

// File: hdl/voxel_ray_traversal_unit.sv
// start transaction: six 32-step passes of the shared restoring divider (crossing
//   and step time per axis) plus a multiply per axis
// advance transaction: cell step, then done check and result load
// one transaction in flight at a time; a result may wait while the next is taken
// reset: cells, end cell, steps and signs cleared, crossings saturated,
//   finished set, ray_reach 100
module voxel_ray_traversal_unit
    import vrt_pkg::*;
#(
    parameter int CELL_BITS = CELL_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [REACH_W-1:0] cfg_data
);

    localparam int PROD_W    = DIR_W + REACH_W + 1;
    localparam int OFS_W     = PROD_W + FRAC_BITS;
    localparam int E_W       = OFS_W + 1;
    localparam int DIST_W    = FRAC_BITS + 1;
    localparam int NUM_SHIFT = T_W - 1 - FRAC_BITS;

    localparam logic signed [CELL_BITS-1:0] CELL_MAX = {1'b0, {(CELL_BITS-1){1'b1}}};
    localparam logic signed [CELL_BITS-1:0] CELL_MIN = {1'b1, {(CELL_BITS-1){1'b0}}};
    localparam logic signed [E_W-1:0]       END_MAX  = E_W'(CELL_MAX);
    localparam logic signed [E_W-1:0]       END_MIN  = E_W'(CELL_MIN);

    seq_state_t state_reg, state_next;

    logic [REACH_W-1:0] reach_reg, reach_next;
    logic [AXIS_W-1:0]  axis_reg, axis_next;
    logic               finished_reg, finished_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;

    logic signed [CELL_BITS-1:0] cur_reg [N_AXES];
    logic signed [CELL_BITS-1:0] cur_next [N_AXES];
    logic signed [CELL_BITS-1:0] prev_reg [N_AXES];
    logic signed [CELL_BITS-1:0] prev_next [N_AXES];
    logic signed [CELL_BITS-1:0] end_reg [N_AXES];
    logic signed [CELL_BITS-1:0] end_next [N_AXES];
    logic [T_W-1:0]              cross_reg [N_AXES];
    logic [T_W-1:0]              cross_next [N_AXES];
    logic [T_W-1:0]              step_reg [N_AXES];
    logic [T_W-1:0]              step_next [N_AXES];
    logic signed [1:0]           sign_reg [N_AXES];
    logic signed [1:0]           sign_next [N_AXES];

    logic signed [POS_W-1:0]  pos_reg [N_AXES];
    logic signed [POS_W-1:0]  pos_next [N_AXES];
    logic signed [DIR_W-1:0]  dir_reg [N_AXES];
    logic signed [DIR_W-1:0]  dir_next [N_AXES];
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic signed [POS_W-1:0] pos_in [N_AXES];
    logic signed [DIR_W-1:0] dir_in [N_AXES];

    div_req_t div_req;
    div_rsp_t div_rsp;

    // per-axis operands of the current setup axis
    logic signed [DIR_W-1:0] dir_a;
    logic [DIR_W-1:0]        mag_a;
    logic                    dir_zero;
    logic signed [OFS_W-1:0] ofs;
    logic signed [E_W-1:0]   end_pos;
    logic signed [E_W-1:0]   end_fl;
    logic signed [CELL_BITS-1:0] end_sat;
    logic [FRAC_BITS-1:0]    frac_a;
    logic [DIST_W-1:0]       dist_a;

    // done check on the registered walk state
    logic [AXIS_W-1:0] pa;
    logic              hit_end;
    logic              beyond;
    logic              at_edge;
    logic              done_chk;
    logic              slot_free;

    vrt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign pos_in[0] = cmd.pos_x;
    assign pos_in[1] = cmd.pos_y;
    assign pos_in[2] = cmd.pos_z;
    assign dir_in[0] = cmd.dir_x;
    assign dir_in[1] = cmd.dir_y;
    assign dir_in[2] = cmd.dir_z;

    // end cell: origin plus direction times reach, floored and saturated
    always_comb
    begin
        dir_a    = dir_reg[axis_reg];
        mag_a    = dir_a[DIR_W-1] ? DIR_W'(-dir_a) : DIR_W'(dir_a);
        dir_zero = (dir_a == '0);
        ofs      = OFS_W'(prod_reg) <<< FRAC_BITS;
        ofs      = ofs >>> (DIR_W - 1);
        end_pos  = E_W'(pos_reg[axis_reg]) + E_W'(ofs);
        end_fl   = end_pos >>> FRAC_BITS;
        if (end_fl > END_MAX)
            end_sat = CELL_MAX;
        else if (end_fl < END_MIN)
            end_sat = CELL_MIN;
        else
            end_sat = end_fl[CELL_BITS-1:0];
        frac_a = pos_reg[axis_reg][FRAC_BITS-1:0];
        if (!dir_a[DIR_W-1])
            dist_a = (DIST_W'(1) << FRAC_BITS) - DIST_W'(frac_a);
        else
            dist_a = DIST_W'(frac_a);
    end

    // done: end cell reached, next crossing past reach, or step leaves cell range
    always_comb
    begin
        pa      = pick_axis(cross_reg[0], cross_reg[1], cross_reg[2]);
        hit_end = (cur_reg[0] == end_reg[0]) && (cur_reg[1] == end_reg[1])
                  && (cur_reg[2] == end_reg[2]);
        beyond  = cross_reg[pa] > (T_W'(reach_reg) << REACH_SHIFT);
        at_edge = ((cur_reg[pa] == CELL_MAX) && (sign_reg[pa] == SIGN_POS))
                  || ((cur_reg[pa] == CELL_MIN) && (sign_reg[pa] == SIGN_NEG));
        done_chk = hit_end || beyond || at_edge;
    end

    assign slot_free = !res_valid_reg || res_ready;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == KIND_START)
                        state_next = ST_MUL;
                    else if (finished_reg)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_MUL:
                state_next = ST_END;
            ST_END:
                state_next = ST_DIV_T;
            ST_DIV_T:
            begin
                if (div_rsp.done)
                    state_next = ST_DIV_S;
            end
            ST_DIV_S:
            begin
                if (div_rsp.done)
                    state_next = (axis_reg == AXIS_LAST) ? ST_CHECK : ST_MUL;
            end
            ST_CHECK, ST_EMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and result register updates
    always_comb
    begin
        reach_next     = reach_reg;
        axis_next      = axis_reg;
        finished_next  = finished_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        end_next       = end_reg;
        cross_next     = cross_reg;
        step_next      = step_reg;
        sign_next      = sign_reg;
        pos_next       = pos_reg;
        dir_next       = dir_reg;
        prod_next      = prod_reg;
        div_req        = '0;

        if (cfg_valid)
            reach_next = cfg_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == KIND_START)
                    begin
                        pos_next  = pos_in;
                        dir_next  = dir_in;
                        axis_next = AXIS_FIRST;
                        for (int i = 0; i < N_AXES; i++)
                        begin
                            cur_next[i]  = CELL_BITS'(pos_in[i] >>> FRAC_BITS);
                            prev_next[i] = CELL_BITS'(pos_in[i] >>> FRAC_BITS);
                        end
                    end
                    else if (!finished_reg)
                    begin
                        prev_next      = cur_reg;
                        cur_next[pa]   = cur_reg[pa] + CELL_BITS'(sign_reg[pa]);
                        cross_next[pa] = sat_add(cross_reg[pa], step_reg[pa]);
                    end
                end
            end
            ST_MUL:
                prod_next = PROD_W'(dir_a) * PROD_W'(signed'({1'b0, reach_reg}));
            ST_END:
            begin
                end_next[axis_reg] = end_sat;
                div_req.start = 1'b1;
                div_req.num   = T_W'(dist_a) << NUM_SHIFT;
                div_req.den   = mag_a;
            end
            ST_DIV_T:
            begin
                if (div_rsp.done)
                begin
                    cross_next[axis_reg] = dir_zero ? {T_W{1'b1}} : div_rsp.quo;
                    div_req.start = 1'b1;
                    div_req.num   = T_W'(1) << (T_W - 1);
                    div_req.den   = mag_a;
                end
            end
            ST_DIV_S:
            begin
                if (div_rsp.done)
                begin
                    step_next[axis_reg] = dir_zero ? '0 : div_rsp.quo;
                    if (dir_zero)
                        sign_next[axis_reg] = SIGN_NONE;
                    else if (dir_a[DIR_W-1])
                        sign_next[axis_reg] = SIGN_NEG;
                    else
                        sign_next[axis_reg] = SIGN_POS;
                    if (axis_reg != AXIS_LAST)
                        axis_next = axis_reg + AXIS_W'(1);
                end
            end
            ST_CHECK, ST_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next   = 1'b1;
                    res_next.cell_x  = OUT_W'(cur_reg[0]);
                    res_next.cell_y  = OUT_W'(cur_reg[1]);
                    res_next.cell_z  = OUT_W'(cur_reg[2]);
                    res_next.prior_x = OUT_W'(prev_reg[0]);
                    res_next.prior_y = OUT_W'(prev_reg[1]);
                    res_next.prior_z = OUT_W'(prev_reg[2]);
                    if (state_reg == ST_CHECK)
                    begin
                        finished_next   = done_chk;
                        res_next.at_end = done_chk;
                    end
                    else
                    begin
                        res_next.at_end = 1'b1;
                    end
                end
            end
            default:
            begin
                res_valid_next = res_valid_reg && !res_ready;
            end
        endcase
    end

    // control and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            reach_reg     <= REACH_RESET;
            axis_reg      <= AXIS_FIRST;
            finished_reg  <= 1'b1;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < N_AXES; i++)
            begin
                cur_reg[i]   <= '0;
                prev_reg[i]  <= '0;
                end_reg[i]   <= '0;
                cross_reg[i] <= {T_W{1'b1}};
                step_reg[i]  <= '0;
                sign_reg[i]  <= SIGN_NONE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            reach_reg     <= reach_next;
            axis_reg      <= axis_next;
            finished_reg  <= finished_next;
            res_valid_reg <= res_valid_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            end_reg       <= end_next;
            cross_reg     <= cross_next;
            step_reg      <= step_next;
            sign_reg      <= sign_next;
        end
    end

    // ray operands and result payload
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        dir_reg  <= dir_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a step moves the walk along one axis at most
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cur_reg[0] != prev_reg[0], cur_reg[1] != prev_reg[1],
                    cur_reg[2] != prev_reg[2]}) <= 1)
        else $error("current and previous cell differ on more than one axis");

    // the divider only finishes while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_T || state_reg == ST_DIV_S))
        else $error("divider result outside a divide wait state");

    // an advance on a finished walk only repeats the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.kind == KIND_ADVANCE && finished_reg)
        |=> (state_reg == ST_EMIT && $stable(cur_reg[0]) && $stable(cur_reg[1])
             && $stable(cur_reg[2])))
        else $error("finished walk changed on advance");

endmodule

// File: hdl/vrt_div.sv
module vrt_div
    import vrt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(T_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(T_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [T_W-1:0]   quo_reg, quo_next;
    logic [DIR_W-1:0] rem_reg, rem_next;
    logic [DIR_W-1:0] den_reg, den_next;
    logic [DIR_W:0]   trial;
    logic [DIR_W:0]   diff;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    assign trial = {rem_reg, quo_reg[T_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DIR_W-1:0];
                quo_next = {quo_reg[T_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIR_W-1:0];
                quo_next = {quo_reg[T_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule
